// ===== rtl/fftsa_pkg.sv =====
package fftsa_pkg;

    localparam int NUM_CARERS    = 8;
    localparam int MAX_INTERVALS = 16;

    localparam int CARER_W  = 3;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;

    localparam int CIDX_W = (NUM_CARERS > 1) ? $clog2(NUM_CARERS) : 1;
    localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
    localparam int DEPTH  = NUM_CARERS * MAX_INTERVALS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ENTRY_W = 2 * TIME_W;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADREQ = 2'd3
    } t_status;

    typedef struct packed {
        logic              fit;
        logic [TIME_W-1:0] slot_s;
        logic [TIME_W-1:0] slot_e;
    } t_fit_res;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [CIDX_W-1:0] carer,
                                                 input logic [CNT_W-1:0]  idx);
        f_addr = ADDR_W'(32'(carer) * MAX_INTERVALS + 32'(idx));
    endfunction

endpackage

// ===== rtl/first_fit_time_slot_allocator.sv =====
// First-fit time slot allocator.
// Requests arrive on the input channel (i_in_valid / o_in_ready) with a carer index,
// a desired start and a desired end. One result per request leaves on the output
// channel (o_out_valid / i_out_ready) with a status, the assigned start and end.
// A request is taken only while the sequencer is idle. It then reads the carer's
// free intervals one at a time from a single-port-read RAM, each with a read state
// and then a check state, through one shared max/add/compare unit. On a fit it
// moves the tail of the table up by one entry, each moved entry read and then written,
// and then writes the two split pieces, the lower one first. A request with its end
// before its start, or for a carer out of range, goes straight to the done state with
// no scan; a full table or no fit ends after the scan, with nothing written. After
// reset every carer holds one interval covering all time; no clearing pass is needed,
// as a carer whose count is one is read as that interval.
// The result sits in an output register; when the receiver stalls it is held there,
// and a following request may be taken but its result waits until the register frees.
module first_fit_time_slot_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [fftsa_pkg::CARER_W-1:0]  i_carer,
    input  logic [fftsa_pkg::TIME_W-1:0]   i_desired_start,
    input  logic [fftsa_pkg::TIME_W-1:0]   i_desired_end,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [fftsa_pkg::STATUS_W-1:0] o_status,
    output logic [fftsa_pkg::TIME_W-1:0]   o_assigned_start,
    output logic [fftsa_pkg::TIME_W-1:0]   o_assigned_end
);
    import fftsa_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_CHK  = 8'b0000_0100,
        S_SHRD = 8'b0000_1000,
        S_SHWR = 8'b0001_0000,
        S_WLO  = 8'b0010_0000,
        S_WHI  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state             r_state;
    logic [CIDX_W-1:0]  r_carer;
    logic [TIME_W-1:0]  r_ds;
    logic [TIME_W-1:0]  r_dur;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_k;
    logic [CNT_W-1:0]   r_hit;
    t_status            r_status;
    logic [TIME_W-1:0]  r_slot_s;
    logic [TIME_W-1:0]  r_slot_e;
    logic [TIME_W-1:0]  r_old_s;
    logic [TIME_W-1:0]  r_old_e;
    logic [CNT_W-1:0]   r_count [NUM_CARERS];

    logic               r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [TIME_W-1:0]  r_out_start;
    logic [TIME_W-1:0]  r_out_end;

    logic               in_xfer;
    logic               out_free;
    logic [CIDX_W-1:0]  in_cidx;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;
    logic [TIME_W-1:0]  cur_s;
    logic [TIME_W-1:0]  cur_e;
    t_fit_res           fit_res;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign in_cidx    = CIDX_W'(i_carer);

    assign cur_s = (r_cnt == CNT_W'(1)) ? '0 : rdata[ENTRY_W-1:TIME_W];
    assign cur_e = (r_cnt == CNT_W'(1)) ? TIME_MAX : rdata[TIME_W-1:0];

    fftsa_fit_unit u_fit (
        .i_ps  (cur_s),
        .i_pe  (cur_e),
        .i_ds  (r_ds),
        .i_dur (r_dur),
        .o_res (fit_res)
    );

    always_comb begin
        we    = 1'b0;
        waddr = f_addr(r_carer, r_k);
        wdata = rdata;
        raddr = f_addr(r_carer, r_idx);
        case (r_state)
            S_SHRD: begin
                raddr = f_addr(r_carer, r_k - CNT_W'(1));
            end
            S_SHWR: begin
                we = 1'b1;
            end
            S_WLO: begin
                we    = 1'b1;
                waddr = f_addr(r_carer, r_hit);
                wdata = {r_old_s, r_slot_s};
            end
            S_WHI: begin
                we    = 1'b1;
                waddr = f_addr(r_carer, r_hit + CNT_W'(1));
                wdata = {r_slot_e, r_old_e};
            end
            default: begin
            end
        endcase
    end

    fftsa_ram #(
        .DW    (ENTRY_W),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int c = 0; c < NUM_CARERS; c++) begin
                r_count[c] <= CNT_W'(1);
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_desired_end < i_desired_start) begin
                            r_state <= S_DONE;
                        end else if (32'(i_carer) >= 32'(NUM_CARERS)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (fit_res.fit) begin
                        if (r_cnt >= CNT_W'(MAX_INTERVALS)) begin
                            r_state <= S_DONE;
                        end else if (r_cnt > r_idx + CNT_W'(1)) begin
                            r_state <= S_SHRD;
                        end else begin
                            r_state <= S_WLO;
                        end
                    end else if (r_idx + CNT_W'(1) >= r_cnt) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_SHRD: begin
                    r_state <= S_SHWR;
                end
                S_SHWR: begin
                    if (r_k - CNT_W'(1) > r_hit + CNT_W'(1)) begin
                        r_state <= S_SHRD;
                    end else begin
                        r_state <= S_WLO;
                    end
                end
                S_WLO: begin
                    r_state <= S_WHI;
                end
                S_WHI: begin
                    r_count[r_carer] <= r_cnt + CNT_W'(1);
                    r_state          <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_carer <= in_cidx;
                r_ds    <= i_desired_start;
                r_dur   <= i_desired_end - i_desired_start;
                r_idx   <= '0;
                r_cnt   <= r_count[in_cidx];
                if (i_desired_end < i_desired_start) begin
                    r_status <= ST_BADREQ;
                end else begin
                    r_status <= ST_NOFIT;
                end
            end
            S_CHK: begin
                if (fit_res.fit) begin
                    r_hit    <= r_idx;
                    r_k      <= r_cnt;
                    r_slot_s <= fit_res.slot_s;
                    r_slot_e <= fit_res.slot_e;
                    r_old_s  <= cur_s;
                    r_old_e  <= cur_e;
                    if (r_cnt >= CNT_W'(MAX_INTERVALS)) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_status <= ST_OK;
                    end
                end else begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
            S_SHWR: begin
                r_k <= r_k - CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_status;
            r_out_start  <= (r_status == ST_OK) ? r_slot_s : '0;
            r_out_end    <= (r_status == ST_OK) ? r_slot_e : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_assigned_start = r_out_start;
    assign o_assigned_end   = r_out_end;

    a_ok_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OK) |-> (o_assigned_end >= o_assigned_start))
        else $error("assigned slot ends before it starts");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_assigned_start == '0 && o_assigned_end == '0))
        else $error("rejected request carries a slot");

    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHRD) |-> (r_k > r_hit + CNT_W'(1) && r_k < CNT_W'(MAX_INTERVALS)))
        else $error("tail move outside the carer's table");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished result not presented");

    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WLO || r_state == S_WHI) |-> (r_status == ST_OK))
        else $error("table written for a request that was not assigned");

endmodule

// ===== rtl/fftsa_ram.sv =====
module fftsa_ram #(
    parameter int DW    = 64,
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fftsa_fit_unit.sv =====
module fftsa_fit_unit (
    input  logic [fftsa_pkg::TIME_W-1:0] i_ps,
    input  logic [fftsa_pkg::TIME_W-1:0] i_pe,
    input  logic [fftsa_pkg::TIME_W-1:0] i_ds,
    input  logic [fftsa_pkg::TIME_W-1:0] i_dur,
    output fftsa_pkg::t_fit_res          o_res
);
    import fftsa_pkg::*;

    logic [TIME_W-1:0] st;
    logic [TIME_W:0]   sum;

    always_comb begin
        st           = (i_ps > i_ds) ? i_ps : i_ds;
        sum          = {1'b0, st} + {1'b0, i_dur};
        o_res.fit    = (sum <= {1'b0, i_pe});
        o_res.slot_s = st;
        o_res.slot_e = sum[TIME_W-1:0];
    end

endmodule
